// File: sv/ebuf_pkg.sv
// Shared types, sizes and codes of the edit buffer with undo log.
package ebuf_pkg;

  localparam int TEXT_AW    = 14;
  localparam int TEXT_DEPTH = 1 << TEXT_AW;
  localparam int LEN_W      = TEXT_AW + 1;
  localparam int LOG_AW     = 10;
  localparam int LOG_DEPTH  = 1 << LOG_AW;
  localparam int LOG_DROP   = LOG_DEPTH / 4;
  localparam int CNT_W      = LOG_AW + 1;
  localparam int CHAR_W     = 8;
  localparam int GRP_W      = 7;
  localparam int LOG_W      = TEXT_AW + CHAR_W + 1 + GRP_W;
  localparam int MAXLEN_W   = 15;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST = MAXLEN_W'(12288);
  localparam logic [GRP_W-1:0]    GRP_RST    = GRP_W'(1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GROUP  = 3'd2,
    OP_UNDO   = 3'd3,
    OP_REDO   = 3'd4,
    OP_READ   = 3'd5,
    OP_SAVE   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NO_UNDO = 3'd2,
    ST_NO_REDO = 3'd3,
    ST_BAD_POS = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_STATUS,
    ACT_GROUP_INC,
    ACT_CLEAN,
    ACT_FIRST,
    ACT_LOG_RD_UNDO,
    ACT_LOG_RD_REDO,
    ACT_UNDO_TAKE,
    ACT_REDO_TAKE,
    ACT_RAW_START,
    ACT_DEL_CAP,
    ACT_SHIFT,
    ACT_FIN,
    ACT_PUSH,
    ACT_DIRTY,
    ACT_TXT_RD,
    ACT_CAP_COUT,
    ACT_PUBLISH
  } act_e;

  typedef struct packed {
    act_e    act;
    status_e st;
  } ebuf_cmd_t;

  typedef struct packed {
    op_e  op;
    logic ins_bad;
    logic full;
    logic pos_bad;
    logic undo_empty;
    logic redo_empty;
    logic match;
    logic raw_ok;
    logic raw_ins;
    logic shift_done;
    logic out_free;
  } ebuf_stat_t;

endpackage

// File: sv/edit_buffer_with_undo_log_top.sv
// Top level of the edit buffer with undo log: controller and datapath.
//
// The block holds a byte text of up to 16384 bytes in a simple dual-port
// memory and a ring of up to 1024 recent edits in a second memory. Each input
// word is one operation; each produces exactly one result word. An insert or
// delete moves every byte above the position by one place, one byte per clock
// through a read-then-write pipeline on the text memory. Undo and redo walk
// their group one log entry at a time, each entry costing a log read, a check
// and one such shift. The result then waits in the output register for as long
// as the receiver stalls it, and the next input word is accepted on the cycle
// after the result is loaded, even while the result waits to be taken. The text
// memory and log memory hold no reset value; only bytes below the current
// length and log entries below the redo limit are ever read. The max_length
// register is to be written through cfg_we_i and cfg_data_i only while the
// block is idle; the block does not enforce this. It limits only new inserts,
// not undo or redo.
module edit_buffer_with_undo_log_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ebuf_pkg::MAXLEN_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    op_i,
  input  logic [ebuf_pkg::TEXT_AW-1:0]  position_i,
  input  logic [ebuf_pkg::CHAR_W-1:0]   char_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [ebuf_pkg::CHAR_W-1:0]   char_out_o,
  output logic [ebuf_pkg::LEN_W-1:0]    text_length_o,
  output logic [ebuf_pkg::LEN_W-1:0]    cursor_pos_o,
  output logic                          modified_o,
  output logic [ebuf_pkg::CNT_W-1:0]    undo_available_o,
  output logic [ebuf_pkg::CNT_W-1:0]    redo_available_o
);
  import ebuf_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  ebuf_cmd_t  cmd;
  ebuf_stat_t stat;

  ebuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ebuf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .position_i       (position_i),
    .char_in_i        (char_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .char_out_o       (char_out_o),
    .text_length_o    (text_length_o),
    .cursor_pos_o     (cursor_pos_o),
    .modified_o       (modified_o),
    .undo_available_o (undo_available_o),
    .redo_available_o (redo_available_o)
  );

endmodule

// File: sv/ebuf_ctrl.sv
// Controller state machine that sequences every operation of the edit buffer.
module ebuf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ebuf_pkg::ebuf_stat_t stat_i,
  output ebuf_pkg::ebuf_cmd_t  cmd_o
);
  import ebuf_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISPATCH = 15'b000000000000010,
    S_U_RD     = 15'b000000000000100,
    S_U_CHK    = 15'b000000000001000,
    S_V_RD     = 15'b000000000010000,
    S_V_CHK    = 15'b000000000100000,
    S_R_START  = 15'b000000001000000,
    S_R_DCAP   = 15'b000000010000000,
    S_R_SHIFT  = 15'b000000100000000,
    S_R_FIN    = 15'b000001000000000,
    S_R_NEXT   = 15'b000010000000000,
    S_PUSH     = 15'b000100000000000,
    S_REP_END  = 15'b001000000000000,
    S_RD_CAP   = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.act  = ACT_NONE;
    cmd_o.st   = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_LATCH;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.ins_bad) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_BAD_POS;
            end else if (stat_i.full) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_FULL;
            end else begin
              state_d = S_R_START;
            end
          end
          OP_DELETE: begin
            if (stat_i.pos_bad) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_BAD_POS;
            end else begin
              state_d = S_R_START;
            end
          end
          OP_GROUP: cmd_o.act = ACT_GROUP_INC;
          OP_UNDO: begin
            if (stat_i.undo_empty) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_NO_UNDO;
            end else begin
              cmd_o.act = ACT_FIRST;
              state_d   = S_U_RD;
            end
          end
          OP_REDO: begin
            if (stat_i.redo_empty) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_NO_REDO;
            end else begin
              cmd_o.act = ACT_FIRST;
              state_d   = S_V_RD;
            end
          end
          OP_READ: begin
            if (stat_i.pos_bad) begin
              cmd_o.act = ACT_STATUS;
              cmd_o.st  = ST_BAD_POS;
            end else begin
              cmd_o.act = ACT_TXT_RD;
              state_d   = S_RD_CAP;
            end
          end
          OP_SAVE: cmd_o.act = ACT_CLEAN;
          default: state_d = S_DONE;
        endcase
      end
      S_U_RD: begin
        cmd_o.act = ACT_LOG_RD_UNDO;
        state_d   = S_U_CHK;
      end
      S_U_CHK: begin
        if (stat_i.match) begin
          cmd_o.act = ACT_UNDO_TAKE;
          state_d   = S_R_START;
        end else begin
          state_d = S_REP_END;
        end
      end
      S_V_RD: begin
        cmd_o.act = ACT_LOG_RD_REDO;
        state_d   = S_V_CHK;
      end
      S_V_CHK: begin
        if (stat_i.match) begin
          cmd_o.act = ACT_REDO_TAKE;
          state_d   = S_R_START;
        end else begin
          state_d = S_REP_END;
        end
      end
      S_R_START: begin
        cmd_o.act = ACT_RAW_START;
        if (!stat_i.raw_ok) begin
          state_d = S_R_FIN;
        end else if (stat_i.raw_ins) begin
          state_d = S_R_SHIFT;
        end else begin
          state_d = S_R_DCAP;
        end
      end
      S_R_DCAP: begin
        cmd_o.act = ACT_DEL_CAP;
        state_d   = S_R_SHIFT;
      end
      S_R_SHIFT: begin
        cmd_o.act = ACT_SHIFT;
        if (stat_i.shift_done) begin
          state_d = S_R_FIN;
        end
      end
      S_R_FIN: begin
        cmd_o.act = ACT_FIN;
        state_d   = S_R_NEXT;
      end
      S_R_NEXT: begin
        case (stat_i.op)
          OP_UNDO: state_d = stat_i.undo_empty ? S_REP_END : S_U_RD;
          OP_REDO: state_d = stat_i.redo_empty ? S_REP_END : S_V_RD;
          default: state_d = S_PUSH;
        endcase
      end
      S_PUSH: begin
        cmd_o.act = ACT_PUSH;
        state_d   = S_DONE;
      end
      S_REP_END: begin
        cmd_o.act = ACT_DIRTY;
        state_d   = S_DONE;
      end
      S_RD_CAP: begin
        cmd_o.act = ACT_CAP_COUT;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.act = ACT_PUBLISH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/ebuf_dp.sv
// Datapath of the edit buffer: text and log memories, counters and result register.
module ebuf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ebuf_pkg::ebuf_cmd_t                     cmd_i,
  output ebuf_pkg::ebuf_stat_t                    stat_o,
  input  logic                                   cfg_we_i,
  input  logic [ebuf_pkg::MAXLEN_W-1:0]          cfg_data_i,
  input  logic [2:0]                             op_i,
  input  logic [ebuf_pkg::TEXT_AW-1:0]           position_i,
  input  logic [ebuf_pkg::CHAR_W-1:0]            char_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [2:0]                             status_o,
  output logic [ebuf_pkg::CHAR_W-1:0]            char_out_o,
  output logic [ebuf_pkg::LEN_W-1:0]             text_length_o,
  output logic [ebuf_pkg::LEN_W-1:0]             cursor_pos_o,
  output logic                                   modified_o,
  output logic [ebuf_pkg::CNT_W-1:0]             undo_available_o,
  output logic [ebuf_pkg::CNT_W-1:0]             redo_available_o
);
  import ebuf_pkg::*;

  logic [CHAR_W-1:0] text_mem [TEXT_DEPTH];
  logic [LOG_W-1:0]  log_mem  [LOG_DEPTH];

  logic [MAXLEN_W-1:0] max_len_q;
  logic [LEN_W-1:0]    len_q, cursor_q;
  logic [LOG_AW-1:0]   base_q;
  logic [CNT_W-1:0]    applied_q, redo_q;
  logic [GRP_W-1:0]    group_q, g_q;
  logic                dirty_q, first_q, pend_q;

  op_e                 op_q;
  logic [TEXT_AW-1:0]  raw_pos_q;
  logic [CHAR_W-1:0]   raw_ch_q, del_ch_q, cout_q;
  logic                raw_ins_q, raw_rep_q, raw_fwd_q, raw_ok_q;
  status_e             status_q;
  logic [TEXT_AW-1:0]  a_q, wa_q;
  logic [LEN_W-1:0]    n_q;
  logic [CHAR_W-1:0]   txt_rdata_q;
  logic [LOG_W-1:0]    log_rdata_q;

  logic                out_valid_q;
  logic [2:0]          o_status_q;
  logic [CHAR_W-1:0]   o_char_q;
  logic [LEN_W-1:0]    o_len_q, o_cursor_q;
  logic                o_mod_q;
  logic [CNT_W-1:0]    o_undo_q, o_redo_q;

  logic [LEN_W-1:0]    limit, pos_ext;
  logic                raw_ok;
  logic [TEXT_AW-1:0]  l_pos;
  logic [CHAR_W-1:0]   l_ch;
  logic                l_kind;
  logic [GRP_W-1:0]    l_grp;
  logic                txt_we, txt_re;
  logic [TEXT_AW-1:0]  txt_wa, txt_ra;
  logic [CHAR_W-1:0]   txt_wd;
  logic                log_we, log_re;
  logic [LOG_AW-1:0]   log_wa, log_ra;
  logic [LOG_W-1:0]    log_wd;
  logic                log_full;
  logic [LOG_AW-1:0]   base_p;
  logic [CNT_W-1:0]    applied_p;

  assign pos_ext = LEN_W'(raw_pos_q);
  assign limit   = (LEN_W'(max_len_q) < LEN_W'(TEXT_DEPTH)) ? LEN_W'(max_len_q)
                                                            : LEN_W'(TEXT_DEPTH);
  assign raw_ok  = raw_ins_q ? ((len_q < LEN_W'(TEXT_DEPTH)) && (pos_ext <= len_q))
                             : (pos_ext < len_q);

  assign l_pos  = log_rdata_q[LOG_W-1 -: TEXT_AW];
  assign l_ch   = log_rdata_q[GRP_W+1 +: CHAR_W];
  assign l_kind = log_rdata_q[GRP_W];
  assign l_grp  = log_rdata_q[GRP_W-1:0];

  assign log_full  = (applied_q >= CNT_W'(LOG_DEPTH));
  assign base_p    = log_full ? LOG_AW'(base_q + LOG_AW'(LOG_DROP)) : base_q;
  assign applied_p = log_full ? CNT_W'(applied_q - CNT_W'(LOG_DROP)) : applied_q;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.ins_bad    = pos_ext > len_q;
    stat_o.full       = len_q >= limit;
    stat_o.pos_bad    = pos_ext >= len_q;
    stat_o.undo_empty = (applied_q == '0);
    stat_o.redo_empty = (applied_q >= redo_q);
    stat_o.match      = first_q || (l_grp == g_q);
    stat_o.raw_ok     = raw_ok;
    stat_o.raw_ins    = raw_ins_q;
    stat_o.shift_done = (n_q == '0) && !pend_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Memory port selection.
  always_comb begin
    txt_we = 1'b0;
    txt_wa = wa_q;
    txt_wd = txt_rdata_q;
    txt_re = 1'b0;
    txt_ra = raw_pos_q;
    log_we = 1'b0;
    log_wa = LOG_AW'(base_p + applied_p[LOG_AW-1:0]);
    log_wd = {raw_pos_q, (raw_ins_q ? raw_ch_q : del_ch_q), raw_ins_q, group_q};
    log_re = 1'b0;
    log_ra = LOG_AW'(base_q + applied_q[LOG_AW-1:0]);
    case (cmd_i.act)
      ACT_SHIFT: begin
        txt_we = pend_q;
        txt_re = (n_q != '0);
        txt_ra = a_q;
      end
      ACT_RAW_START: txt_re = raw_ok && !raw_ins_q;
      ACT_TXT_RD:    txt_re = 1'b1;
      ACT_FIN: begin
        txt_we = raw_ok_q && raw_ins_q;
        txt_wa = raw_pos_q;
        txt_wd = raw_ch_q;
      end
      ACT_PUSH: log_we = 1'b1;
      ACT_LOG_RD_UNDO: begin
        log_re = 1'b1;
        log_ra = LOG_AW'(base_q + applied_q[LOG_AW-1:0] - LOG_AW'(1));
      end
      ACT_LOG_RD_REDO: log_re = 1'b1;
      default: txt_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      text_mem[txt_wa] <= txt_wd;
    end
    if (txt_re) begin
      txt_rdata_q <= text_mem[txt_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (log_we) begin
      log_mem[log_wa] <= log_wd;
    end
    if (log_re) begin
      log_rdata_q <= log_mem[log_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAXLEN_RST;
      len_q       <= '0;
      cursor_q    <= '0;
      base_q      <= '0;
      applied_q   <= '0;
      redo_q      <= '0;
      group_q     <= GRP_RST;
      dirty_q     <= 1'b0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (cmd_i.act == ACT_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.act)
        ACT_GROUP_INC: group_q <= group_q + GRP_W'(1);
        ACT_CLEAN:     dirty_q <= 1'b0;
        ACT_DIRTY:     dirty_q <= 1'b1;
        ACT_FIRST:     first_q <= 1'b1;
        ACT_UNDO_TAKE: begin
          first_q   <= 1'b0;
          applied_q <= applied_q - CNT_W'(1);
        end
        ACT_REDO_TAKE: first_q <= 1'b0;
        ACT_RAW_START: begin
          pend_q <= 1'b0;
          if (!raw_ok) begin
            n_q <= '0;
          end else if (raw_ins_q) begin
            n_q <= len_q - pos_ext;
          end else begin
            n_q <= len_q - pos_ext - LEN_W'(1);
          end
        end
        ACT_SHIFT: begin
          pend_q <= (n_q != '0);
          if (n_q != '0) begin
            n_q <= n_q - LEN_W'(1);
          end
        end
        ACT_FIN: begin
          if (raw_ok_q) begin
            if (raw_ins_q) begin
              len_q <= len_q + LEN_W'(1);
              if (raw_rep_q) begin
                cursor_q <= pos_ext + LEN_W'(1);
              end
            end else begin
              len_q <= len_q - LEN_W'(1);
              if (raw_rep_q) begin
                cursor_q <= pos_ext;
              end
            end
          end
          if (raw_rep_q && raw_fwd_q) begin
            applied_q <= applied_q + CNT_W'(1);
          end
        end
        ACT_PUSH: begin
          base_q    <= base_p;
          applied_q <= applied_p + CNT_W'(1);
          redo_q    <= applied_p + CNT_W'(1);
          dirty_q   <= 1'b1;
        end
        default: dirty_q <= dirty_q;
      endcase
    end
  end

  // Item and shift payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      ACT_LATCH: begin
        op_q      <= op_e'(op_i);
        raw_pos_q <= position_i;
        raw_ch_q  <= char_in_i;
        raw_ins_q <= (op_e'(op_i) == OP_INSERT);
        raw_rep_q <= 1'b0;
        raw_fwd_q <= 1'b0;
        status_q  <= ST_OK;
        cout_q    <= '0;
      end
      ACT_STATUS: status_q <= cmd_i.st;
      ACT_UNDO_TAKE, ACT_REDO_TAKE: begin
        g_q       <= l_grp;
        raw_pos_q <= l_pos;
        raw_ch_q  <= l_ch;
        raw_rep_q <= 1'b1;
        raw_fwd_q <= (cmd_i.act == ACT_REDO_TAKE);
        raw_ins_q <= (cmd_i.act == ACT_REDO_TAKE) ? l_kind : !l_kind;
      end
      ACT_RAW_START: begin
        raw_ok_q <= raw_ok;
        a_q      <= raw_ins_q ? TEXT_AW'(len_q - LEN_W'(1)) : raw_pos_q + TEXT_AW'(1);
      end
      ACT_SHIFT: begin
        if (n_q != '0) begin
          wa_q <= raw_ins_q ? a_q + TEXT_AW'(1) : a_q - TEXT_AW'(1);
          a_q  <= raw_ins_q ? a_q - TEXT_AW'(1) : a_q + TEXT_AW'(1);
        end
      end
      ACT_DEL_CAP:  del_ch_q <= txt_rdata_q;
      ACT_CAP_COUT: cout_q   <= txt_rdata_q;
      ACT_PUSH: begin
        if (!raw_ins_q) begin
          cout_q <= del_ch_q;
        end
      end
      ACT_PUBLISH: begin
        o_status_q <= status_q;
        o_char_q   <= cout_q;
        o_len_q    <= len_q;
        o_cursor_q <= cursor_q;
        o_mod_q    <= dirty_q;
        o_undo_q   <= applied_q;
        o_redo_q   <= redo_q - applied_q;
      end
      default: cout_q <= cout_q;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign char_out_o       = o_char_q;
  assign text_length_o    = o_len_q;
  assign cursor_pos_o     = o_cursor_q;
  assign modified_o       = o_mod_q;
  assign undo_available_o = o_undo_q;
  assign redo_available_o = o_redo_q;

endmodule
